/* design/dfn_pkg.sv */
// shared types and constants for the distributed flow shop dispatch block
// no dependencies; imported by the controller, the datapath and the top level
package dfn_pkg;

  // sizing
  localparam int MAX_JOBS      = 64;
  localparam int MAX_MACHINES  = 32;
  localparam int MAX_FACTORIES = 8;
  localparam int TIME_WIDTH    = 16;

  // derived index and count widths
  localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int FW  = (MAX_FACTORIES > 1) ? $clog2(MAX_FACTORIES) : 1;
  localparam int FCW = $clog2(MAX_FACTORIES + 1);

  // port field widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int NJ_W       = 7;
  localparam int NM_W       = 6;
  localparam int NF_W       = 4;
  localparam int JOB_IDX_W  = 7;
  localparam int MACH_IDX_W = 6;
  localparam int FAC_ID_W   = 4;
  localparam int POS_W      = 7;
  localparam int MS_W       = 24;
  localparam int TOT_W      = 22;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_JOBS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_MACHINES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FACTORIES = 2'd2;

  // source of a sequence memory write
  typedef enum logic [1:0] {
    SEQ_FROM_SORT = 2'd0,
    SEQ_FROM_SEQ  = 2'd1,
    SEQ_FROM_INS  = 2'd2
  } seq_wsel_t;

  // controller to datapath commands
  typedef struct packed {
    logic                  load_en;
    logic [JW-1:0]         tm_job;
    logic [MW-1:0]         tm_mach;
    logic                  tm_use_cur;
    logic                  acc_add;
    logic                  acc_first;
    logic [JW-1:0]         tot_addr;
    logic                  tot_wr;
    logic                  best_clr;
    logic                  best_cmp;
    logic                  chosen_clr;
    logic [JW-1:0]         sort_addr;
    logic                  sort_wr;
    logic                  ins_ld;
    logic [FW+JW-1:0]      seq_addr;
    logic                  seq_wr;
    seq_wsel_t             seq_wsel;
    logic                  cur_ld_seq;
    logic                  cur_ld_ins;
    logic                  row_clr;
    logic                  row_step;
    logic                  row_first;
    logic                  bm_ld;
    logic                  out_ld;
    logic [FAC_ID_W-1:0]   out_factory;
    logic [POS_W-1:0]      out_position;
    logic                  out_last;
  } dfn_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic ms_lt;
    logic out_free;
  } dfn_sts_t;

endpackage

/* design/dfn_datapath.sv */
// datapath: time table, totals, order, factory sequences, completion row, result register
// depends on dfn_pkg; driven by dfn_ctrl through dfn_cmd_t
module dfn_datapath
  import dfn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dfn_cmd_t              cmd,
  output dfn_sts_t              sts,
  input  logic [JOB_IDX_W-1:0]  in_job_index,
  input  logic [MACH_IDX_W-1:0] in_machine_index,
  input  logic [TIME_WIDTH-1:0] in_proc_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FAC_ID_W-1:0]   out_factory_id,
  output logic [POS_W-1:0]      out_position,
  output logic [JOB_IDX_W-1:0]  out_job_id,
  output logic [MS_W-1:0]       out_factory_makespan,
  output logic                  out_last_result
);

  localparam logic [MS_W:0] MS_MAX = {1'b0, {MS_W{1'b1}}};

  // storage
  logic [TIME_WIDTH-1:0] time_mem [MAX_JOBS*MAX_MACHINES];
  logic [TOT_W-1:0]      tot_mem  [MAX_JOBS];
  logic [JW-1:0]         sort_mem [MAX_JOBS];
  logic [JW-1:0]         seq_mem  [MAX_FACTORIES*MAX_JOBS];
  logic [MS_W-1:0]       row_r    [MAX_MACHINES];
  logic [MAX_JOBS-1:0]   chosen_r;

  logic [TIME_WIDTH-1:0] tm_rdata_r;
  logic [TOT_W-1:0]      tot_rdata_r;
  logic [JW-1:0]         sort_rdata_r;
  logic [JW-1:0]         seq_rdata_r;
  logic [TOT_W-1:0]      acc_r;
  logic [TOT_W-1:0]      best_tot_r;
  logic [JW-1:0]         best_idx_r;
  logic                  best_vld_r;
  logic [JW-1:0]         ins_job_r;
  logic [JW-1:0]         cur_job_r;
  logic [MS_W-1:0]       prev_r;
  logic [MS_W-1:0]       best_ms_r;
  logic                  out_valid_r;
  logic [FAC_ID_W-1:0]   out_factory_r;
  logic [POS_W-1:0]      out_position_r;
  logic [JOB_IDX_W-1:0]  out_job_r;
  logic [MS_W-1:0]       out_ms_r;
  logic                  out_last_r;

  logic                  ld_ok;
  logic [JW-1:0]         ld_job;
  logic [MW-1:0]         ld_mach;
  logic [JW-1:0]         rd_job;
  logic [MS_W-1:0]       row_sel;
  logic [MS_W-1:0]       row_prev;
  logic [MS_W-1:0]       row_start;
  logic [MS_W:0]         row_sum;
  logic [MS_W-1:0]       row_new;
  logic [JW-1:0]         seq_wdata;
  logic                  best_take;

  // load address decode
  always_comb begin
    ld_ok   = (in_job_index != '0) && (in_job_index <= JOB_IDX_W'(MAX_JOBS)) &&
              (in_machine_index != '0) && (in_machine_index <= MACH_IDX_W'(MAX_MACHINES));
    ld_job  = JW'(in_job_index - JOB_IDX_W'(1));
    ld_mach = MW'(in_machine_index - MACH_IDX_W'(1));
    rd_job  = cmd.tm_use_cur ? cur_job_r : cmd.tm_job;
  end

  // time table: load writes, registered read
  always_ff @(posedge clk) begin
    if (cmd.load_en && ld_ok) begin
      time_mem[{ld_job, ld_mach}] <= in_proc_time;
    end
    tm_rdata_r <= time_mem[{rd_job, cmd.tm_mach}];
  end

  // job totals memory
  always_ff @(posedge clk) begin
    if (cmd.tot_wr) begin
      tot_mem[cmd.tot_addr] <= acc_r;
    end
    tot_rdata_r <= tot_mem[cmd.tot_addr];
  end

  // sorted order memory
  always_ff @(posedge clk) begin
    if (cmd.sort_wr) begin
      sort_mem[cmd.sort_addr] <= best_idx_r;
    end
    sort_rdata_r <= sort_mem[cmd.sort_addr];
  end

  // factory sequence memory, single port
  always_comb begin
    unique case (cmd.seq_wsel)
      SEQ_FROM_SORT: seq_wdata = sort_rdata_r;
      SEQ_FROM_SEQ:  seq_wdata = seq_rdata_r;
      SEQ_FROM_INS:  seq_wdata = ins_job_r;
      default:       seq_wdata = ins_job_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.seq_wr) begin
      seq_mem[cmd.seq_addr] <= seq_wdata;
    end
    seq_rdata_r <= seq_mem[cmd.seq_addr];
  end

  // total accumulation
  always_ff @(posedge clk) begin
    if (cmd.acc_add) begin
      acc_r <= cmd.acc_first ? TOT_W'(tm_rdata_r) : acc_r + TOT_W'(tm_rdata_r);
    end
  end

  // largest-total search, lowest index wins ties
  assign best_take = !chosen_r[cmd.tot_addr] && (!best_vld_r || (tot_rdata_r > best_tot_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
      chosen_r   <= '0;
    end else begin
      if (cmd.best_clr) begin
        best_vld_r <= 1'b0;
      end else if (cmd.best_cmp && best_take) begin
        best_vld_r <= 1'b1;
      end
      if (cmd.chosen_clr) begin
        chosen_r <= '0;
      end else if (cmd.sort_wr) begin
        chosen_r[best_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.best_cmp && best_take) begin
      best_tot_r <= tot_rdata_r;
      best_idx_r <= cmd.tot_addr;
    end
  end

  // job registers
  always_ff @(posedge clk) begin
    if (cmd.ins_ld) begin
      ins_job_r <= sort_rdata_r;
    end
    if (cmd.cur_ld_seq) begin
      cur_job_r <= seq_rdata_r;
    end else if (cmd.cur_ld_ins) begin
      cur_job_r <= ins_job_r;
    end
  end

  // completion row step
  always_comb begin
    row_sel   = row_r[cmd.tm_mach];
    row_prev  = cmd.row_first ? '0 : prev_r;
    row_start = (row_sel > row_prev) ? row_sel : row_prev;
    row_sum   = {1'b0, row_start} + (MS_W + 1)'(tm_rdata_r);
    row_new   = (row_sum > MS_MAX) ? MS_W'(MS_MAX) : row_sum[MS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.row_clr) begin
      for (int m = 0; m < MAX_MACHINES; m++) begin
        row_r[m] <= '0;
      end
    end else if (cmd.row_step) begin
      row_r[cmd.tm_mach] <= row_new;
    end
    if (cmd.row_step) begin
      prev_r <= row_new;
    end
    if (cmd.bm_ld) begin
      best_ms_r <= row_sel;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_factory_r  <= cmd.out_factory;
      out_position_r <= cmd.out_position;
      out_job_r      <= JOB_IDX_W'(seq_rdata_r) + JOB_IDX_W'(1);
      out_ms_r       <= best_ms_r;
      out_last_r     <= cmd.out_last;
    end
  end

  assign sts.ms_lt    = row_sel < best_ms_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_factory_id       = out_factory_r;
  assign out_position         = out_position_r;
  assign out_job_id           = out_job_r;
  assign out_factory_makespan = out_ms_r;
  assign out_last_result      = out_last_r;

endmodule

/* design/dfn_ctrl.sv */
// controller: configuration registers, loop counters and the scheduling state machine
// depends on dfn_pkg; commands dfn_datapath through dfn_cmd_t
module dfn_ctrl
  import dfn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_load_last,
  input  dfn_sts_t              sts,
  output dfn_cmd_t              cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_TOT_RD, S_TOT_ADD, S_TOT_WR, S_SRT_INIT, S_SRT_RD, S_SRT_CMP, S_SRT_WR,
    S_PL_RD, S_PL_WR, S_ASG_RD, S_ASG_LD, S_MS_CLR, S_MS_ELEM, S_MS_SEQ, S_MS_TRD,
    S_MS_CALC, S_MS_DONE, S_SH, S_SH_RD, S_SH_WR, S_EM_RD, S_EM_LD
  } state_t;

  typedef enum logic [1:0] {
    R_EVF, R_EVP, R_EMIT
  } ret_t;

  state_t           state_r, state_nxt;
  ret_t             ret_r, ret_nxt;
  logic [NJ_W-1:0]  num_jobs_r, num_jobs_nxt;
  logic [NM_W-1:0]  num_machines_r, num_machines_nxt;
  logic [NF_W-1:0]  num_factories_r, num_factories_nxt;
  logic [CW-1:0]    nj_r, nj_nxt;
  logic [MW-1:0]    nm1_r, nm1_nxt;
  logic [FCW-1:0]   nf_r, nf_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [MW-1:0]    k_r, k_nxt;
  logic [FCW-1:0]   f_r, f_nxt;
  logic [CW-1:0]    r_r, r_nxt;
  logic [CW-1:0]    e_r, e_nxt;
  logic [CW-1:0]    p_r, p_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [FW-1:0]    bf_r, bf_nxt;
  logic [CW-1:0]    bp_r, bp_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [FW-1:0]    ef_r, ef_nxt;
  logic             ins_r, ins_nxt;
  logic [CW-1:0]    cnt_r [MAX_FACTORIES];
  logic [CW-1:0]    cnt_nxt [MAX_FACTORIES];

  logic [CW-1:0]    nj_c;
  logic [MW-1:0]    nm1_c;
  logic [FCW-1:0]   nf_c;
  logic [CW-1:0]    tlen;
  logic [CW-1:0]    eidx;
  logic             take;

  // clamped settings taken at schedule start
  always_comb begin
    if (num_jobs_r == '0) begin
      nj_c = CW'(1);
    end else if (num_jobs_r > NJ_W'(MAX_JOBS)) begin
      nj_c = CW'(MAX_JOBS);
    end else begin
      nj_c = CW'(num_jobs_r);
    end
    if (num_machines_r == '0) begin
      nm1_c = '0;
    end else if (num_machines_r > NM_W'(MAX_MACHINES)) begin
      nm1_c = MW'(MAX_MACHINES - 1);
    end else begin
      nm1_c = MW'(num_machines_r - NM_W'(1));
    end
    if (num_factories_r == '0) begin
      nf_c = FCW'(1);
    end else if (num_factories_r > NF_W'(MAX_FACTORIES)) begin
      nf_c = FCW'(MAX_FACTORIES);
    end else begin
      nf_c = FCW'(num_factories_r);
    end
    if (CW'(nf_c) > nj_c) begin
      nf_c = FCW'(nj_c);
    end
  end

  // next state and commands
  always_comb begin
    state_nxt         = state_r;
    ret_nxt           = ret_r;
    num_jobs_nxt      = num_jobs_r;
    num_machines_nxt  = num_machines_r;
    num_factories_nxt = num_factories_r;
    nj_nxt  = nj_r;
    nm1_nxt = nm1_r;
    nf_nxt  = nf_r;
    i_nxt   = i_r;
    k_nxt   = k_r;
    f_nxt   = f_r;
    r_nxt   = r_r;
    e_nxt   = e_r;
    p_nxt   = p_r;
    idx_nxt = idx_r;
    bf_nxt  = bf_r;
    bp_nxt  = bp_r;
    n_nxt   = n_r;
    ef_nxt  = ef_r;
    ins_nxt = ins_r;
    cnt_nxt = cnt_r;
    cmd     = '0;
    in_stall = 1'b1;
    take     = 1'b0;

    tlen = cnt_r[ef_r] + CW'(ins_r);
    eidx = (ins_r && (e_r > p_r)) ? e_r - CW'(1) : e_r;

    // configuration writes
    if (cfg_we) begin
      priority case (cfg_index)
        CFG_NUM_JOBS:      num_jobs_nxt      = cfg_wdata[NJ_W-1:0];
        CFG_NUM_MACHINES:  num_machines_nxt  = cfg_wdata[NM_W-1:0];
        CFG_NUM_FACTORIES: num_factories_nxt = cfg_wdata[NF_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        in_stall       = 1'b0;
        cmd.load_en    = in_valid;
        cmd.chosen_clr = 1'b1;
        if (in_valid && in_load_last) begin
          nj_nxt  = nj_c;
          nm1_nxt = nm1_c;
          nf_nxt  = nf_c;
          i_nxt   = '0;
          k_nxt   = '0;
          for (int q = 0; q < MAX_FACTORIES; q++) begin
            cnt_nxt[q] = '0;
          end
          state_nxt = S_TOT_RD;
        end
      end

      // per-job totals
      S_TOT_RD: begin
        cmd.tm_job  = i_r[JW-1:0];
        cmd.tm_mach = k_r;
        state_nxt   = S_TOT_ADD;
      end
      S_TOT_ADD: begin
        cmd.acc_add   = 1'b1;
        cmd.acc_first = (k_r == '0);
        if (k_r == nm1_r) begin
          state_nxt = S_TOT_WR;
        end else begin
          k_nxt     = k_r + MW'(1);
          state_nxt = S_TOT_RD;
        end
      end
      S_TOT_WR: begin
        cmd.tot_addr = i_r[JW-1:0];
        cmd.tot_wr   = 1'b1;
        k_nxt        = '0;
        if (i_r == nj_r - CW'(1)) begin
          r_nxt     = '0;
          state_nxt = S_SRT_INIT;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_TOT_RD;
        end
      end

      // ordering by repeated largest-total search
      S_SRT_INIT: begin
        cmd.best_clr = 1'b1;
        i_nxt        = '0;
        state_nxt    = S_SRT_RD;
      end
      S_SRT_RD: begin
        cmd.tot_addr = i_r[JW-1:0];
        state_nxt    = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        cmd.tot_addr = i_r[JW-1:0];
        cmd.best_cmp = 1'b1;
        if (i_r == nj_r - CW'(1)) begin
          state_nxt = S_SRT_WR;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SRT_RD;
        end
      end
      S_SRT_WR: begin
        cmd.sort_addr = r_r[JW-1:0];
        cmd.sort_wr   = 1'b1;
        if (r_r == nj_r - CW'(1)) begin
          f_nxt     = '0;
          state_nxt = S_PL_RD;
        end else begin
          r_nxt     = r_r + CW'(1);
          state_nxt = S_SRT_INIT;
        end
      end

      // first jobs open one factory each
      S_PL_RD: begin
        cmd.sort_addr = JW'(f_r);
        state_nxt     = S_PL_WR;
      end
      S_PL_WR: begin
        cmd.seq_addr  = {f_r[FW-1:0], {JW{1'b0}}};
        cmd.seq_wr    = 1'b1;
        cmd.seq_wsel  = SEQ_FROM_SORT;
        cnt_nxt[f_r[FW-1:0]] = CW'(1);
        if (f_r == nf_r - FCW'(1)) begin
          i_nxt = CW'(nf_r);
          if (CW'(nf_r) == nj_r) begin
            take = 1'b1;
          end else begin
            state_nxt = S_ASG_RD;
          end
        end else begin
          f_nxt     = f_r + FCW'(1);
          state_nxt = S_PL_RD;
        end
      end

      // next job to place
      S_ASG_RD: begin
        cmd.sort_addr = i_r[JW-1:0];
        state_nxt     = S_ASG_LD;
      end
      S_ASG_LD: begin
        cmd.ins_ld = 1'b1;
        f_nxt      = '0;
        ef_nxt     = '0;
        ins_nxt    = 1'b0;
        ret_nxt    = R_EVF;
        state_nxt  = S_MS_CLR;
      end

      // makespan of one sequence, optionally with the new job inserted
      S_MS_CLR: begin
        cmd.row_clr = 1'b1;
        e_nxt       = '0;
        state_nxt   = S_MS_ELEM;
      end
      S_MS_ELEM: begin
        k_nxt = '0;
        if (ins_r && (e_r == p_r)) begin
          cmd.cur_ld_ins = 1'b1;
          state_nxt      = S_MS_TRD;
        end else begin
          cmd.seq_addr = {ef_r, eidx[JW-1:0]};
          state_nxt    = S_MS_SEQ;
        end
      end
      S_MS_SEQ: begin
        cmd.cur_ld_seq = 1'b1;
        state_nxt      = S_MS_TRD;
      end
      S_MS_TRD: begin
        cmd.tm_use_cur = 1'b1;
        cmd.tm_mach    = k_r;
        state_nxt      = S_MS_CALC;
      end
      S_MS_CALC: begin
        cmd.tm_mach   = k_r;
        cmd.row_step  = 1'b1;
        cmd.row_first = (k_r == '0);
        if (k_r == nm1_r) begin
          if (e_r + CW'(1) == tlen) begin
            state_nxt = S_MS_DONE;
          end else begin
            e_nxt     = e_r + CW'(1);
            state_nxt = S_MS_ELEM;
          end
        end else begin
          k_nxt     = k_r + MW'(1);
          state_nxt = S_MS_TRD;
        end
      end
      S_MS_DONE: begin
        cmd.tm_mach = nm1_r;
        unique case (ret_r)
          R_EVF: begin
            if ((f_r == '0) || sts.ms_lt) begin
              cmd.bm_ld = 1'b1;
              bf_nxt    = f_r[FW-1:0];
            end
            if (f_r == nf_r - FCW'(1)) begin
              ef_nxt  = bf_nxt;
              ins_nxt = 1'b1;
              p_nxt   = '0;
              ret_nxt = R_EVP;
            end else begin
              f_nxt  = f_r + FCW'(1);
              ef_nxt = FW'(f_r + FCW'(1));
            end
            state_nxt = S_MS_CLR;
          end
          R_EVP: begin
            if ((p_r == '0) || sts.ms_lt) begin
              cmd.bm_ld = 1'b1;
              bp_nxt    = p_r;
            end
            if (p_r == cnt_r[bf_r]) begin
              idx_nxt   = cnt_r[bf_r];
              state_nxt = S_SH;
            end else begin
              p_nxt     = p_r + CW'(1);
              state_nxt = S_MS_CLR;
            end
          end
          R_EMIT: begin
            cmd.bm_ld = 1'b1;
            idx_nxt   = '0;
            state_nxt = S_EM_RD;
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      // open a gap at the chosen place and drop the job in
      S_SH: begin
        if (idx_r == bp_r) begin
          cmd.seq_addr = {bf_r, bp_r[JW-1:0]};
          cmd.seq_wr   = 1'b1;
          cmd.seq_wsel = SEQ_FROM_INS;
          cnt_nxt[bf_r] = cnt_r[bf_r] + CW'(1);
          if (i_r == nj_r - CW'(1)) begin
            take = 1'b1;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = S_ASG_RD;
          end
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd.seq_addr = {bf_r, JW'(idx_r - CW'(1))};
        state_nxt    = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.seq_addr = {bf_r, idx_r[JW-1:0]};
        cmd.seq_wr   = 1'b1;
        cmd.seq_wsel = SEQ_FROM_SEQ;
        idx_nxt      = idx_r - CW'(1);
        state_nxt    = S_SH;
      end

      // result emission, factory by factory
      S_EM_RD: begin
        cmd.seq_addr = {f_r[FW-1:0], idx_r[JW-1:0]};
        state_nxt    = S_EM_LD;
      end
      S_EM_LD: begin
        cmd.seq_addr = {f_r[FW-1:0], idx_r[JW-1:0]};
        if (sts.out_free) begin
          cmd.out_ld       = 1'b1;
          cmd.out_factory  = FAC_ID_W'(f_r) + FAC_ID_W'(1);
          cmd.out_position = POS_W'(idx_r) + POS_W'(1);
          cmd.out_last     = (n_r == nj_r - CW'(1));
          n_nxt            = n_r + CW'(1);
          if (idx_r + CW'(1) == cnt_r[f_r[FW-1:0]]) begin
            if (f_r == nf_r - FCW'(1)) begin
              state_nxt = S_IDLE;
            end else begin
              f_nxt     = f_r + FCW'(1);
              ef_nxt    = FW'(f_r + FCW'(1));
              ins_nxt   = 1'b0;
              state_nxt = S_MS_CLR;
            end
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // start of emission
    if (take) begin
      f_nxt     = '0;
      ef_nxt    = '0;
      ins_nxt   = 1'b0;
      n_nxt     = '0;
      ret_nxt   = R_EMIT;
      state_nxt = S_MS_CLR;
    end
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      ret_r           <= R_EVF;
      num_jobs_r      <= NJ_W'(1);
      num_machines_r  <= NM_W'(1);
      num_factories_r <= NF_W'(1);
      nj_r  <= CW'(1);
      nm1_r <= '0;
      nf_r  <= FCW'(1);
      i_r   <= '0;
      k_r   <= '0;
      f_r   <= '0;
      r_r   <= '0;
      e_r   <= '0;
      p_r   <= '0;
      idx_r <= '0;
      bf_r  <= '0;
      bp_r  <= '0;
      n_r   <= '0;
      ef_r  <= '0;
      ins_r <= 1'b0;
      for (int q = 0; q < MAX_FACTORIES; q++) begin
        cnt_r[q] <= '0;
      end
    end else begin
      state_r         <= state_nxt;
      ret_r           <= ret_nxt;
      num_jobs_r      <= num_jobs_nxt;
      num_machines_r  <= num_machines_nxt;
      num_factories_r <= num_factories_nxt;
      nj_r  <= nj_nxt;
      nm1_r <= nm1_nxt;
      nf_r  <= nf_nxt;
      i_r   <= i_nxt;
      k_r   <= k_nxt;
      f_r   <= f_nxt;
      r_r   <= r_nxt;
      e_r   <= e_nxt;
      p_r   <= p_nxt;
      idx_r <= idx_nxt;
      bf_r  <= bf_nxt;
      bp_r  <= bp_nxt;
      n_r   <= n_nxt;
      ef_r  <= ef_nxt;
      ins_r <= ins_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/distributed_flowshop_neh_dispatch.sv */
// load requests: one per cycle while idle; a non-last request produces no result
// last request: totals are summed from the time table, then the jobs are ordered by
// repeated largest-total search over the totals memory; each makespan evaluation
// over L jobs then runs once per factory per placed job and once per trial place
// results: one makespan evaluation per factory, then its results in order
// reset (rst_n low, synchronous): idle, registers at 1, no result pending
module distributed_flowshop_neh_dispatch
  import dfn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [JOB_IDX_W-1:0]  in_job_index,
  input  logic [MACH_IDX_W-1:0] in_machine_index,
  input  logic [TIME_WIDTH-1:0] in_proc_time,
  input  logic                  in_load_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FAC_ID_W-1:0]   out_factory_id,
  output logic [POS_W-1:0]      out_position,
  output logic [JOB_IDX_W-1:0]  out_job_id,
  output logic [MS_W-1:0]       out_factory_makespan,
  output logic                  out_last_result
);

  dfn_cmd_t cmd;
  dfn_sts_t sts;

  // sequencer
  dfn_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_load_last (in_load_last),
    .sts          (sts),
    .cmd          (cmd)
  );

  // storage and arithmetic
  dfn_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_job_index         (in_job_index),
    .in_machine_index     (in_machine_index),
    .in_proc_time         (in_proc_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_factory_id       (out_factory_id),
    .out_position         (out_position),
    .out_job_id           (out_job_id),
    .out_factory_makespan (out_factory_makespan),
    .out_last_result      (out_last_result)
  );

endmodule
